### hdl/okq_pkg.sv
`default_nettype none
package okq_pkg;

	localparam int unsigned ITEMS_DEF  = 1024;
	localparam int unsigned GROUPS_DEF = 128;

	localparam int unsigned KIND_W  = 3;
	localparam int unsigned ID_W    = 10;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned GROUP_W = 7;

	localparam logic [KIND_W-1:0] KIND_ADD          = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE       = 3'd1;
	localparam logic [KIND_W-1:0] KIND_GROUP_PICK   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_GLOBAL_PICK  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LEVEL_SEARCH = 3'd4;

	typedef enum logic [1:0] {
		MODE_ALL,
		MODE_GROUP,
		MODE_AT_OR_ABOVE,
		MODE_BELOW
	} mode_t;

	typedef struct packed {
		logic               valid;
		logic [LEVEL_W-1:0] level;
		logic [GROUP_W-1:0] grp;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	typedef struct packed {
		mode_t              mode;
		logic [GROUP_W-1:0] grp;
		logic [LEVEL_W-1:0] thr;
		logic               want_max;
	} query_t;

endpackage
`default_nettype wire

### hdl/ordered_key_table_query_top.sv
// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+-------------------------------
// command   | kind, item_id, level, group, direction        | taken when start && !busy
// result    | found, result_id                              | one-cycle strobe on done
//
// Add and remove write the table in the cycle they are taken; busy stays low.
// A pick or level search walks the table through the single RAM read port, one
// entry per cycle, so it holds busy through the scan and a drain state and strobes
// done in the first cycle with busy low.
// After reset busy stays high while the table is cleared.
// The receiver cannot stall: done marks each result word for one cycle only.
`default_nettype none
module ordered_key_table_query_top #(
	parameter int unsigned ITEMS  = okq_pkg::ITEMS_DEF,
	parameter int unsigned GROUPS = okq_pkg::GROUPS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [okq_pkg::KIND_W-1:0]   kind,
	input  wire logic [okq_pkg::ID_W-1:0]     item_id,
	input  wire logic [okq_pkg::LEVEL_W-1:0]  level,
	input  wire logic [okq_pkg::GROUP_W-1:0]  group,
	input  wire logic                         direction,
	output logic                              done,
	output logic                              found,
	output logic      [okq_pkg::ID_W-1:0]     result_id
);

	import okq_pkg::*;

	localparam int unsigned AW    = $clog2(ITEMS);
	localparam int unsigned KEY_W = LEVEL_W + AW;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]       state_q;
	logic [AW-1:0]    ptr_q;
	logic             ptr_last;
	query_t           query_q;
	query_t           query_in;
	logic             rd_vld_s1;
	logic [AW-1:0]    rd_idx_s1;
	logic             have_q;
	logic [KEY_W-1:0] best_q;
	logic             done_q;
	logic             found_q;
	logic [ID_W-1:0]  result_id_q;

	logic             accept;
	logic             is_query;
	logic             id_ok;
	logic             grp_ok;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	entry_t           ram_wdata;
	logic             ram_re;
	entry_t           ram_rdata;
	logic             take;
	logic             have_fin;
	logic [AW-1:0]    id_fin;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign ptr_last = (ptr_q == AW'(ITEMS - 1));
	assign id_ok    = (32'(item_id) < ITEMS);
	assign grp_ok   = (32'(group) < GROUPS);
	assign is_query = (kind == KIND_GROUP_PICK) || (kind == KIND_GLOBAL_PICK) ||
		(kind == KIND_LEVEL_SEARCH);

	always_comb begin
		query_in.grp      = group;
		query_in.thr      = level;
		query_in.mode     = MODE_ALL;
		query_in.want_max = direction;
		if (kind == KIND_GROUP_PICK) begin
			query_in.mode = MODE_GROUP;
		end else if (kind == KIND_LEVEL_SEARCH) begin
			query_in.mode     = direction ? MODE_AT_OR_ABOVE : MODE_BELOW;
			query_in.want_max = !direction;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (accept && id_ok) begin
			ram_waddr = AW'(item_id);
			if (kind == KIND_ADD && grp_ok) begin
				ram_we          = 1'b1;
				ram_wdata.valid = 1'b1;
				ram_wdata.level = level;
				ram_wdata.grp   = group;
			end else if (kind == KIND_REMOVE) begin
				ram_we = 1'b1;
			end
		end
	end

	assign ram_re = (state_q == ST_SCAN);

	okq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ITEMS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	okq_cmp #(
		.IDX_W (AW)
	) u_cmp (
		.query (query_q),
		.entry (ram_rdata),
		.idx   (rd_idx_s1),
		.have  (have_q),
		.best  (best_q),
		.take  (take)
	);

	assign have_fin = have_q || (rd_vld_s1 && take);
	assign id_fin   = (rd_vld_s1 && take) ? rd_idx_s1 : best_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			have_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			done_q    <= 1'b0;
			if (rd_vld_s1 && take) begin
				have_q <= 1'b1;
			end
			unique case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_last) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && is_query) begin
						ptr_q   <= '0;
						have_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_last) begin
						ptr_q   <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q;
		if (accept && is_query) begin
			query_q <= query_in;
		end
		if (rd_vld_s1 && take) begin
			best_q <= {ram_rdata.level, rd_idx_s1};
		end
		if (state_q == ST_DRAIN) begin
			found_q     <= have_fin;
			result_id_q <= have_fin ? ID_W'(id_fin) : '0;
		end
	end

	assign done      = done_q;
	assign found     = found_q;
	assign result_id = result_id_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !found_q) |-> (result_id_q == '0))
		else $error("result_id nonzero on a miss");

	a_query_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_query) |=> (state_q == ST_SCAN))
		else $error("query taken without starting a scan");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) || (state_q == ST_DRAIN)) |-> !ram_we)
		else $error("table written during a scan");

	a_drain_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (done_q && (state_q == ST_IDLE)))
		else $error("scan end did not deliver a result");

endmodule
`default_nettype wire

### hdl/okq_ram.sv
`default_nettype none
module okq_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### hdl/okq_cmp.sv
`default_nettype none
module okq_cmp #(
	parameter int unsigned IDX_W = 10
) (
	input  wire okq_pkg::query_t                          query,
	input  wire okq_pkg::entry_t                          entry,
	input  wire logic [IDX_W-1:0]                         idx,
	input  wire logic                                     have,
	input  wire logic [okq_pkg::LEVEL_W+IDX_W-1:0]        best,
	output logic                                          take
);

	import okq_pkg::*;

	localparam int unsigned KEY_W = LEVEL_W + IDX_W;

	logic             ok;
	logic [KEY_W-1:0] key;
	logic             better;

	always_comb begin
		unique case (query.mode)
			MODE_ALL:         ok = entry.valid;
			MODE_GROUP:       ok = entry.valid && (entry.grp == query.grp);
			MODE_AT_OR_ABOVE: ok = entry.valid && (entry.level >= query.thr);
			MODE_BELOW:       ok = entry.valid && (entry.level < query.thr);
			default:          ok = 1'b0;
		endcase
	end

	assign key    = {entry.level, idx};
	assign better = query.want_max ? (key > best) : (key < best);
	assign take   = ok && (!have || better);

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import okq_pkg::*;

	localparam int unsigned TABLE_SIZE   = ITEMS_DEF;
	localparam int unsigned RANDOM_WORDS = 555;
	localparam int unsigned QUIET_LIMIT  = 8 * (TABLE_SIZE + 2) + 2000;

	typedef struct {
		logic [KIND_W-1:0]  op;
		logic [ID_W-1:0]    id;
		logic [LEVEL_W-1:0] lvl;
		logic [GROUP_W-1:0] grp;
		logic               dir;
		bit                 drain;
	} cmd_t;

	typedef struct {
		logic            hit;
		logic [ID_W-1:0] id;
	} answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [KIND_W-1:0]  kind = KIND_ADD;
	logic [ID_W-1:0]    item_id = '0;
	logic [LEVEL_W-1:0] level = '0;
	logic [GROUP_W-1:0] group = '0;
	logic               direction = 1'b0;
	logic               busy;
	logic               done;
	logic               found;
	logic [ID_W-1:0]    result_id;

	cmd_t    pending_cmds[$];
	answer_t answers_due[$];

	bit                 present[TABLE_SIZE];
	logic [LEVEL_W-1:0] level_of[TABLE_SIZE];
	logic [GROUP_W-1:0] group_of[TABLE_SIZE];

	bit          took = 1'b0;
	int unsigned words_sent = 0;
	int unsigned mismatches = 0;
	int unsigned quiet = 0;
	cmd_t        next_cmd;

	ordered_key_table_query_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.item_id(item_id),
		.level(level),
		.group(group),
		.direction(direction),
		.done(done),
		.found(found),
		.result_id(result_id)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic cmd_t make_cmd(logic [KIND_W-1:0] op, logic [ID_W-1:0] id,
			logic [LEVEL_W-1:0] lvl, logic [GROUP_W-1:0] grp, logic dir);
		cmd_t c;
		c.op = op;
		c.id = id;
		c.lvl = lvl;
		c.grp = grp;
		c.dir = dir;
		c.drain = 1'b0;
		return c;
	endfunction

	function automatic cmd_t drain_marker();
		cmd_t c;
		c = make_cmd(KIND_ADD, '0, '0, '0, 1'b0);
		c.drain = 1'b1;
		return c;
	endfunction

	function automatic answer_t best_entry(mode_t mode, logic [GROUP_W-1:0] grp,
			logic [LEVEL_W-1:0] thr, logic want_max);
		answer_t a;
		logic [LEVEL_W+ID_W-1:0] best;
		logic [LEVEL_W+ID_W-1:0] key;
		bit ok;
		a.hit = 1'b0;
		a.id = '0;
		best = '0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (present[i]) begin
				case (mode)
					MODE_GROUP: ok = (group_of[i] == grp);
					MODE_AT_OR_ABOVE: ok = (level_of[i] >= thr);
					MODE_BELOW: ok = (level_of[i] < thr);
					default: ok = 1'b1;
				endcase
				key = {level_of[i], i[ID_W-1:0]};
				if (ok && (!a.hit || (want_max ? (key > best) : (key < best)))) begin
					a.hit = 1'b1;
					a.id = i[ID_W-1:0];
					best = key;
				end
			end
		end
		return a;
	endfunction

	task automatic apply_word(logic [KIND_W-1:0] op, logic [ID_W-1:0] id,
			logic [LEVEL_W-1:0] lvl, logic [GROUP_W-1:0] grp, logic dir);
		case (op)
			KIND_ADD: begin
				if (id < TABLE_SIZE && grp < GROUPS_DEF) begin
					present[id] = 1'b1;
					level_of[id] = lvl;
					group_of[id] = grp;
				end
			end
			KIND_REMOVE: begin
				if (id < TABLE_SIZE)
					present[id] = 1'b0;
			end
			KIND_GROUP_PICK: answers_due.push_back(best_entry(MODE_GROUP, grp, '0, dir));
			KIND_GLOBAL_PICK: answers_due.push_back(best_entry(MODE_ALL, '0, '0, dir));
			KIND_LEVEL_SEARCH: begin
				if (dir)
					answers_due.push_back(best_entry(MODE_AT_OR_ABOVE, '0, lvl, 1'b0));
				else
					answers_due.push_back(best_entry(MODE_BELOW, '0, lvl, 1'b1));
			end
			default: ;
		endcase
	endtask

	task automatic note_mismatch(string what, int unsigned want, int unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			took <= start && !busy;
			if (done) begin
				if (answers_due.size() == 0) begin
					note_mismatch("unexpected word", 0, 1);
				end else begin
					if (found !== answers_due[0].hit)
						note_mismatch("found", 32'(answers_due[0].hit), 32'(found));
					if (result_id !== answers_due[0].id)
						note_mismatch("result_id", 32'(answers_due[0].id), 32'(result_id));
					void'(answers_due.pop_front());
				end
			end
			if (start && !busy)
				apply_word(kind, item_id, level, group, direction);
			if (done || (start && !busy))
				quiet <= 0;
			else
				quiet <= quiet + 1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (pending_cmds.size() > 0 && pending_cmds[0].drain) begin
				start <= 1'b0;
				if (answers_due.size() == 0)
					void'(pending_cmds.pop_front());
			end else if (pending_cmds.size() > 0 &&
					!((words_sent < 150 || words_sent >= 300) && $urandom_range(99) < 15)) begin
				next_cmd = pending_cmds.pop_front();
				start <= 1'b1;
				kind <= next_cmd.op;
				item_id <= next_cmd.id;
				level <= next_cmd.lvl;
				group <= next_cmd.grp;
				direction <= next_cmd.dir;
				words_sent <= words_sent + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic logic [ID_W-1:0] pick_id();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return ID_W'($urandom_range(31));
		else if (r < 85)
			return ID_W'($urandom_range(1023, 992));
		return ID_W'($urandom_range(1023));
	endfunction

	function automatic logic [LEVEL_W-1:0] pick_level();
		if ($urandom_range(99) < 40)
			return LEVEL_W'($urandom_range(3) * 85);
		return LEVEL_W'($urandom_range(255));
	endfunction

	function automatic logic [GROUP_W-1:0] pick_group();
		if ($urandom_range(99) < 80)
			return GROUP_W'($urandom_range(3));
		return GROUP_W'($urandom_range(127));
	endfunction

	initial begin
		int unsigned made;
		int unsigned r;
		logic [KIND_W-1:0] op;

		pending_cmds.push_back(make_cmd(KIND_GLOBAL_PICK, 10'd0, 8'd0, 7'd0, 1'b1));
		pending_cmds.push_back(make_cmd(KIND_LEVEL_SEARCH, 10'd0, 8'd0, 7'd0, 1'b1));
		pending_cmds.push_back(make_cmd(KIND_ADD, 10'd1023, 8'd255, 7'd127, 1'b0));
		pending_cmds.push_back(make_cmd(KIND_ADD, 10'd0, 8'd0, 7'd0, 1'b1));
		pending_cmds.push_back(make_cmd(KIND_ADD, 10'd5, 8'd255, 7'd127, 1'b0));
		pending_cmds.push_back(make_cmd(KIND_ADD, 10'd700, 8'd0, 7'd3, 1'b0));
		pending_cmds.push_back(make_cmd(KIND_GLOBAL_PICK, 10'd1023, 8'd255, 7'd127, 1'b1));
		pending_cmds.push_back(make_cmd(KIND_GLOBAL_PICK, 10'd0, 8'd0, 7'd0, 1'b0));
		pending_cmds.push_back(make_cmd(KIND_GROUP_PICK, 10'd0, 8'd0, 7'd127, 1'b0));
		pending_cmds.push_back(make_cmd(KIND_GROUP_PICK, 10'd0, 8'd0, 7'd127, 1'b1));
		pending_cmds.push_back(make_cmd(KIND_GROUP_PICK, 10'd0, 8'd0, 7'd64, 1'b1));
		pending_cmds.push_back(make_cmd(KIND_LEVEL_SEARCH, 10'd0, 8'd255, 7'd0, 1'b1));
		pending_cmds.push_back(make_cmd(KIND_LEVEL_SEARCH, 10'd0, 8'd0, 7'd0, 1'b0));
		pending_cmds.push_back(make_cmd(KIND_LEVEL_SEARCH, 10'd0, 8'd255, 7'd0, 1'b0));
		pending_cmds.push_back(make_cmd(KIND_LEVEL_SEARCH, 10'd0, 8'd1, 7'd0, 1'b1));
		pending_cmds.push_back(make_cmd(KIND_ADD, 10'd5, 8'd100, 7'd3, 1'b1));
		pending_cmds.push_back(make_cmd(KIND_GROUP_PICK, 10'd0, 8'd0, 7'd3, 1'b1));
		pending_cmds.push_back(make_cmd(KIND_REMOVE, 10'd300, 8'd0, 7'd0, 1'b0));
		pending_cmds.push_back(make_cmd(KIND_REMOVE, 10'd0, 8'd0, 7'd0, 1'b0));
		pending_cmds.push_back(make_cmd(3'd5, 10'd1, 8'd1, 7'd1, 1'b1));
		pending_cmds.push_back(make_cmd(3'd6, 10'd2, 8'd2, 7'd2, 1'b0));
		pending_cmds.push_back(make_cmd(3'd7, 10'd3, 8'd3, 7'd3, 1'b1));
		pending_cmds.push_back(make_cmd(KIND_GLOBAL_PICK, 10'd0, 8'd0, 7'd0, 1'b0));
		pending_cmds.push_back(make_cmd(KIND_LEVEL_SEARCH, 10'd0, 8'd101, 7'd0, 1'b0));
		pending_cmds.push_back(drain_marker());

		made = 0;
		while (made < RANDOM_WORDS) begin
			r = $urandom_range(99);
			if (r < 35)
				op = KIND_ADD;
			else if (r < 50)
				op = KIND_REMOVE;
			else if (r < 63)
				op = KIND_GROUP_PICK;
			else if (r < 73)
				op = KIND_GLOBAL_PICK;
			else if (r < 97)
				op = KIND_LEVEL_SEARCH;
			else
				op = KIND_W'($urandom_range(7, 5));
			pending_cmds.push_back(make_cmd(op, pick_id(), pick_level(), pick_group(),
				1'($urandom_range(1))));
			if (op <= KIND_LEVEL_SEARCH)
				made++;
			if (made == 300)
				pending_cmds.push_back(drain_marker());
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_cmds.size() != 0 || start)
			@(posedge clk);
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (TABLE_SIZE + 20) @(posedge clk);

		if (mismatches == 0 && answers_due.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		while (quiet < QUIET_LIMIT)
			@(posedge clk);
		$display("testbench: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

### sim.f
hdl/okq_pkg.sv
hdl/okq_ram.sv
hdl/okq_cmp.sv
hdl/ordered_key_table_query_top.sv
tb/sv/testbench.sv
